// ===== rtl/slfd_pkg.sv =====
// Shared types, constants and codes for the start-marker frame deframer.
`default_nettype none
package slfd_pkg;

    localparam int DEF_HEADER_BYTES = 8;
    localparam int DEF_CRC_BYTES    = 2;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 16;
    localparam int BL_W       = LEN_W + 1;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int VERSION_AT = 2;
    localparam int LENGTH_AT  = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SOF_FIRST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOF_SECOND  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd3;

    localparam logic [BYTE_W-1:0] RST_SOF_FIRST   = 8'd170;
    localparam logic [BYTE_W-1:0] RST_SOF_SECOND  = 8'd85;
    localparam logic [BYTE_W-1:0] RST_VERSION     = 8'd1;
    localparam logic [LEN_W-1:0]  RST_MAX_PAYLOAD = 16'd1024;

    localparam logic [KIND_W-1:0] KIND_FRAME        = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SKIP_VERSION = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SKIP_LENGTH  = 2'd2;

    typedef struct packed {
        logic              mode;
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_feed;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic [BYTE_W-1:0] out_byte;
        logic              frame_first;
        logic              frame_last;
        logic              burst_last;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_FLUSH,
        OP_HUNT,
        OP_HEADER,
        OP_PASS,
        OP_REJECT,
        OP_ACCEPT,
        OP_EMIT,
        OP_SCAN
    } t_dp_op;

    typedef struct packed {
        logic hunt_pair;
        logic header_full;
        logic pass_end;
        logic out_busy;
        logic out_free;
        logic reject;
        logic emit_done;
        logic total_zero;
        logic scan_match;
        logic scan_end;
    } t_dp_status;

endpackage
`default_nettype wire

// ===== rtl/slfd_dp.sv =====
// Datapath: config registers, header shift store, counters and output register.
`default_nettype none
module slfd_dp
    import slfd_pkg::*;
#(
    parameter int HEADER_BYTES = DEF_HEADER_BYTES,
    parameter int CRC_BYTES    = DEF_CRC_BYTES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_in_item              i_in_data,
    input  wire logic                  i_out_stall,
    input  wire t_dp_op                i_op,
    output t_dp_status                 o_status,
    output logic                       o_out_valid,
    output t_out_item                  o_out_data
);

    localparam int FILL_W = $clog2(HEADER_BYTES + 1);
    localparam int IDX_W  = $clog2(HEADER_BYTES);

    logic [BYTE_W-1:0] r_store [HEADER_BYTES];
    logic [FILL_W-1:0] r_fill;
    logic [IDX_W-1:0]  r_cnt;
    logic [BL_W-1:0]   r_bytes_left;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [BYTE_W-1:0] r_sof_first;
    logic [BYTE_W-1:0] r_sof_second;
    logic [BYTE_W-1:0] r_version;
    logic [LEN_W-1:0]  r_max_payload;

    logic [BYTE_W-1:0] b;
    logic [LEN_W-1:0]  len;
    logic [BL_W-1:0]   total;
    logic              ver_bad;
    logic              len_bad;
    logic              shift_en;
    logic              out_load;
    t_dp_status        st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sof_first   <= RST_SOF_FIRST;
            r_sof_second  <= RST_SOF_SECOND;
            r_version     <= RST_VERSION;
            r_max_payload <= RST_MAX_PAYLOAD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SOF_FIRST:   r_sof_first   <= i_cfg_data[BYTE_W-1:0];
                CFG_SOF_SECOND:  r_sof_second  <= i_cfg_data[BYTE_W-1:0];
                CFG_VERSION:     r_version     <= i_cfg_data[BYTE_W-1:0];
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        b       = i_in_data.in_byte;
        len     = {r_store[LENGTH_AT+1], r_store[LENGTH_AT]};
        total   = {1'b0, len} + BL_W'(CRC_BYTES);
        ver_bad = r_store[VERSION_AT] != r_version;
        len_bad = len > r_max_payload;

        st.hunt_pair   = (r_fill == FILL_W'(1)) && (b == r_sof_second);
        st.header_full = r_fill == FILL_W'(HEADER_BYTES - 1);
        st.pass_end    = r_bytes_left <= BL_W'(1);
        st.out_busy    = r_out_valid;
        st.out_free    = !r_out_valid || !i_out_stall;
        st.reject      = ver_bad || len_bad;
        st.emit_done   = r_cnt == IDX_W'(HEADER_BYTES - 1);
        st.total_zero  = r_bytes_left == '0;
        st.scan_end    = r_cnt < IDX_W'(2);
        st.scan_match  = !st.scan_end && (r_store[0] == r_sof_first)
                         && (r_store[1] == r_sof_second);

        shift_en = (i_op == OP_REJECT) || (i_op == OP_EMIT)
                   || ((i_op == OP_SCAN) && !st.scan_match && !st.scan_end);
        out_load = (i_op == OP_PASS) || (i_op == OP_REJECT) || (i_op == OP_EMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_cnt        <= '0;
            r_bytes_left <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_op)
                OP_FLUSH: begin
                    r_fill       <= '0;
                    r_bytes_left <= '0;
                end
                OP_HUNT: begin
                    if (st.hunt_pair) begin
                        r_fill <= FILL_W'(2);
                    end else if (b == r_sof_first) begin
                        r_fill <= FILL_W'(1);
                    end else begin
                        r_fill <= '0;
                    end
                end
                OP_HEADER: r_fill <= r_fill + FILL_W'(1);
                OP_PASS: begin
                    if (r_bytes_left != '0) begin
                        r_bytes_left <= r_bytes_left - BL_W'(1);
                    end
                    r_fill <= '0;
                end
                OP_REJECT: begin
                    r_cnt <= IDX_W'(HEADER_BYTES - 1);
                end
                OP_ACCEPT: begin
                    r_fill       <= '0;
                    r_cnt        <= '0;
                    r_bytes_left <= total;
                end
                OP_EMIT: begin
                    r_cnt <= r_cnt + IDX_W'(1);
                end
                OP_SCAN: begin
                    if (st.scan_match) begin
                        r_fill <= FILL_W'(r_cnt);
                    end else if (st.scan_end) begin
                        r_fill <= (r_store[0] == r_sof_first) ? FILL_W'(1) : '0;
                    end else begin
                        r_cnt <= r_cnt - IDX_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift_en) begin
            for (int k = 0; k < HEADER_BYTES - 1; k++) begin
                r_store[k] <= r_store[k+1];
            end
        end
        unique case (i_op)
            OP_HUNT: begin
                if (st.hunt_pair) begin
                    r_store[1] <= b;
                end else if (b == r_sof_first) begin
                    r_store[0] <= b;
                end
            end
            OP_HEADER: r_store[r_fill[IDX_W-1:0]] <= b;
            OP_PASS: begin
                r_out.result_kind <= KIND_FRAME;
                r_out.out_byte    <= b;
                r_out.frame_first <= 1'b0;
                r_out.frame_last  <= st.pass_end;
                r_out.burst_last  <= 1'b1;
            end
            OP_REJECT: begin
                r_out.result_kind <= ver_bad ? KIND_SKIP_VERSION : KIND_SKIP_LENGTH;
                r_out.out_byte    <= '0;
                r_out.frame_first <= 1'b0;
                r_out.frame_last  <= 1'b0;
                r_out.burst_last  <= 1'b1;
            end
            OP_EMIT: begin
                r_out.result_kind <= KIND_FRAME;
                r_out.out_byte    <= r_store[0];
                r_out.frame_first <= r_cnt == '0;
                r_out.frame_last  <= st.emit_done && st.total_zero;
                r_out.burst_last  <= st.emit_done;
            end
            default: ;
        endcase
    end

    assign o_status    = st;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ===== rtl/slfd_ctrl.sv =====
// Controller: framing state machine that sequences the datapath.
`default_nettype none
module slfd_ctrl
    import slfd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_mode,
    input  wire t_dp_status i_status,
    output logic            o_in_stall,
    output t_dp_op          o_op
);

    typedef enum logic [2:0] {
        S_HUNT,
        S_HEADER,
        S_PASS,
        S_CHECK,
        S_EMIT,
        S_SCAN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_ready;
    logic   acc;

    always_comb begin
        in_ready = ((r_state == S_HUNT) || (r_state == S_HEADER) || (r_state == S_PASS))
                   && !i_status.out_busy;
        acc      = i_in_valid && in_ready;
        n_state  = r_state;
        o_op     = OP_NONE;
        unique case (r_state)
            S_HUNT: begin
                if (acc) begin
                    if (i_in_mode) begin
                        o_op = OP_FLUSH;
                    end else begin
                        o_op    = OP_HUNT;
                        n_state = i_status.hunt_pair ? S_HEADER : S_HUNT;
                    end
                end
            end
            S_HEADER: begin
                if (acc) begin
                    if (i_in_mode) begin
                        o_op    = OP_FLUSH;
                        n_state = S_HUNT;
                    end else begin
                        o_op    = OP_HEADER;
                        n_state = i_status.header_full ? S_CHECK : S_HEADER;
                    end
                end
            end
            S_PASS: begin
                if (acc) begin
                    if (i_in_mode) begin
                        o_op    = OP_FLUSH;
                        n_state = S_HUNT;
                    end else begin
                        o_op    = OP_PASS;
                        n_state = i_status.pass_end ? S_HUNT : S_PASS;
                    end
                end
            end
            S_CHECK: begin
                if (!i_status.reject) begin
                    o_op    = OP_ACCEPT;
                    n_state = S_EMIT;
                end else if (i_status.out_free) begin
                    o_op    = OP_REJECT;
                    n_state = S_SCAN;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_op = OP_EMIT;
                    if (i_status.emit_done) begin
                        n_state = i_status.total_zero ? S_HUNT : S_PASS;
                    end
                end
            end
            S_SCAN: begin
                o_op = OP_SCAN;
                if (i_status.scan_match) begin
                    n_state = S_HEADER;
                end else if (i_status.scan_end) begin
                    n_state = S_HUNT;
                end
            end
            default: n_state = S_HUNT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = !in_ready;

endmodule
`default_nettype wire

// ===== rtl/sof_length_frame_deframer.sv =====
// Top level of the start-marker, length-prefixed frame deframer.
// One byte is taken per request and the block works on one request at a time. For a
// payload/CRC byte, the byte is taken, its result sits in the single output register, and
// no new request is taken until that register is empty. The byte that completes the header
// is followed by a check step, then either the header is sent from the header shift store
// and the last header byte must leave before the next request is taken, or one skip result
// is sent and the store is rescanned, shifting one byte a cycle, looking for a new marker
// pair. Downstream stall holds the skip result, the header send and the payload bytes.
`default_nettype none
module sof_length_frame_deframer
    import slfd_pkg::*;
#(
    parameter int HEADER_BYTES = DEF_HEADER_BYTES,
    parameter int CRC_BYTES    = DEF_CRC_BYTES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_data
);

    t_dp_op     op;
    t_dp_status status;

    slfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_mode  (i_in_data.mode),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_op       (op)
    );

    slfd_dp #(
        .HEADER_BYTES (HEADER_BYTES),
        .CRC_BYTES    (CRC_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_op        (op),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_no_take_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> !o_out_valid)
        else $error("request taken while a result waits");

    a_flush_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.mode) |=> !o_out_valid)
        else $error("flush produced a result");

    a_skip_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.result_kind != KIND_FRAME))
        |-> (o_out_data.burst_last && !o_out_data.frame_first && !o_out_data.frame_last))
        else $error("skip result with frame marks or open burst");

    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_last) |-> o_out_data.burst_last)
        else $error("frame end without burst end");

endmodule
`default_nettype wire
